// File: rtl/core/cdt_pkg.sv
// Shared types and constants for the 3-4 chamfer distance transform.
// No dependencies; used by cdt_relax and chamfer_distance_transform_unit.
package cdt_pkg;

    localparam int DIST_W    = 12;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;
    localparam int IDX_W     = 16;

    localparam logic [DIST_W-1:0] DIST_INF      = 12'd4095;
    localparam logic [DIST_W-1:0] STEP_STRAIGHT = 12'd3;
    localparam logic [DIST_W-1:0] STEP_DIAG     = 12'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

    // input opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_BWD_RD,
        S_BWD_WR,
        S_READ
    } t_state;

    // which neighbor terms take part in one relaxation
    typedef struct packed {
        logic prev;
        logic near;
        logic diag;
        logic far;
    } t_nb_en;

    function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] d,
                                                  input logic [DIST_W-1:0] step);
        logic [DIST_W:0] s;
        s = {1'b0, d} + {1'b0, step};
        return (s > {1'b0, DIST_INF}) ? DIST_INF : s[DIST_W-1:0];
    endfunction

endpackage

// File: rtl/core/cdt_relax.sv
// One chamfer relaxation: minimum of a center value and up to four
// saturated neighbor terms. Depends on cdt_pkg.
module cdt_relax (
    input  logic [cdt_pkg::DIST_W-1:0] i_center,
    input  logic [cdt_pkg::DIST_W-1:0] i_prev,
    input  logic [cdt_pkg::DIST_W-1:0] i_near,
    input  logic [cdt_pkg::DIST_W-1:0] i_diag,
    input  logic [cdt_pkg::DIST_W-1:0] i_far,
    input  cdt_pkg::t_nb_en            i_en,
    output logic [cdt_pkg::DIST_W-1:0] o_dist
);

    logic [cdt_pkg::DIST_W-1:0] w_prev_t;
    logic [cdt_pkg::DIST_W-1:0] w_near_t;
    logic [cdt_pkg::DIST_W-1:0] w_diag_t;
    logic [cdt_pkg::DIST_W-1:0] w_far_t;
    logic [cdt_pkg::DIST_W-1:0] w_m0;
    logic [cdt_pkg::DIST_W-1:0] w_m1;
    logic [cdt_pkg::DIST_W-1:0] w_m2;

    // disabled terms fall back to the sentinel so they never win
    assign w_prev_t = i_en.prev ? cdt_pkg::sat_add(i_prev, cdt_pkg::STEP_STRAIGHT)
                                : cdt_pkg::DIST_INF;
    assign w_near_t = i_en.near ? cdt_pkg::sat_add(i_near, cdt_pkg::STEP_STRAIGHT)
                                : cdt_pkg::DIST_INF;
    assign w_diag_t = i_en.diag ? cdt_pkg::sat_add(i_diag, cdt_pkg::STEP_DIAG)
                                : cdt_pkg::DIST_INF;
    assign w_far_t  = i_en.far  ? cdt_pkg::sat_add(i_far, cdt_pkg::STEP_DIAG)
                                : cdt_pkg::DIST_INF;

    assign w_m0   = (w_prev_t < w_near_t) ? w_prev_t : w_near_t;
    assign w_m1   = (w_diag_t < w_far_t) ? w_diag_t : w_far_t;
    assign w_m2   = (w_m0 < w_m1) ? w_m0 : w_m1;
    assign o_dist = (i_center < w_m2) ? i_center : w_m2;

endmodule

// File: rtl/core/chamfer_distance_transform_unit.sv
// Top level of the 3-4 chamfer distance transform with its distance memory.
// Depends on cdt_pkg and cdt_relax.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one item per transfer.
//   Op load takes the next pixel in raster order; op read fetches the distance
//   at i_read_index. Only reads produce a result on the output channel
//   (o_out_valid / i_out_ready), held in an output register.
//   Load: a memory read of the row above, then relax and write back.
//   The forward pass runs as pixels arrive.
//   After the last pixel of a frame the backward pass walks the frame from
//   the end, pixel by pixel (read two entries, relax and write back), and
//   o_in_ready stays low until it has finished.
//   Read: memory is read on the transfer; o_out_valid rises as the read leaves S_READ.
//   ready_res is 1 only once both passes are done and the index is inside
//   the frame, otherwise distance reads as 0.
//   A stalled receiver holds a read in its result state; loads are still
//   taken while a result waits in the output register.
//   Reset (synchronous, active low) restores 256 x 256 geometry (clamped to
//   the maximum) and clears frame progress; memory contents are not cleared.
//   Config writes (width, height) restart the frame and must come while idle.
module chamfer_distance_transform_unit #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cdt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cdt_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_op,
    input  logic                          i_pixel_set,
    input  logic [cdt_pkg::IDX_W-1:0]     i_read_index,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [cdt_pkg::DIST_W-1:0]    o_distance,
    output logic                          o_ready_res
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int IXW   = CW + cdt_pkg::IDX_W;
    localparam int W_RST = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
    localparam int H_RST = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;

    localparam int DW = cdt_pkg::DIST_W;

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    cdt_pkg::t_state r_state, n_state;

    logic [WW-1:0] r_w;            // effective width
    logic [HW-1:0] r_h;            // effective height
    logic [CW-1:0] r_cnt;          // pixel index, forward and backward
    logic [WW-1:0] r_x;
    logic [HW-1:0] r_y;
    logic          r_frame_done;
    logic          r_set;          // registered pixel_set of the load
    logic          r_rd_ok;        // read hits a finished frame

    // neighbor window: prev = left/right, near = up/down, diag = up-left/down-right
    logic [DW-1:0] r_prev;
    logic [DW-1:0] r_near;
    logic [DW-1:0] r_diag;

    logic          r_out_valid;
    logic [DW-1:0] r_distance;
    logic          r_ready_res;

    // distance memory: one write port, two registered read ports
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rda_q;
    logic [DW-1:0] r_rdb_q;

    logic          w_rda_en;
    logic [AW-1:0] w_rda_addr;
    logic          w_rdb_en;
    logic [AW-1:0] w_rdb_addr;
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;

    // ---------------------------------------------------------------
    // Geometry and position
    // ---------------------------------------------------------------
    logic [CW-1:0]  w_n;
    logic [CW-1:0]  w_w_ext;
    logic           w_in_xfer;
    logic           w_restart;
    logic [CW-1:0]  w_i_eff;
    logic [CW-1:0]  w_fwd_addr;
    logic [CW-1:0]  w_bwd_addr;
    logic [IXW-1:0] w_idx_ext;
    logic           w_idx_in;
    logic           w_x_first, w_x_last, w_y_first, w_y_last;
    logic           w_last_px;
    logic           w_w_one;
    logic           w_out_free;
    logic [WW-1:0]  w_cfg_w;
    logic [HW-1:0]  w_cfg_h;

    assign w_n       = CW'(r_w) * CW'(r_h);
    assign w_w_ext   = CW'(r_w);
    assign w_in_xfer = i_in_valid && o_in_ready;
    assign w_restart = r_frame_done || (r_cnt >= w_n);
    assign w_i_eff   = w_restart ? '0 : r_cnt;

    // forward: entry one past the pixel above, i.e. up-right of this pixel,
    // or at row end the up neighbor of the next row's first pixel
    assign w_fwd_addr = w_i_eff + CW'(1) - w_w_ext;
    // backward: mirror image, down-left or the next pixel's down neighbor
    assign w_bwd_addr = r_cnt - CW'(1) + w_w_ext;

    assign w_idx_ext = IXW'(i_read_index);
    assign w_idx_in  = w_idx_ext < IXW'(w_n);

    assign w_x_first = (r_x == '0);
    assign w_y_first = (r_y == '0);
    assign w_x_last  = ((r_x + WW'(1)) == r_w);
    assign w_y_last  = ((r_y + HW'(1)) == r_h);
    assign w_last_px = ((r_cnt + CW'(1)) == w_n);
    assign w_w_one   = (r_w == WW'(1));
    assign w_out_free = !r_out_valid || i_out_ready;

    // zero acts as one, oversize clamps to the maximum
    assign w_cfg_w = (i_cfg_data == '0) ? WW'(1) :
                     ((32'(i_cfg_data) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(i_cfg_data));
    assign w_cfg_h = (i_cfg_data == '0) ? HW'(1) :
                     ((32'(i_cfg_data) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(i_cfg_data));

    // ---------------------------------------------------------------
    // Relaxation unit, shared by both passes
    // ---------------------------------------------------------------
    cdt_pkg::t_nb_en w_en;
    logic [DW-1:0]   w_center;
    logic [DW-1:0]   w_new;
    logic            w_bwd;

    assign w_bwd = (r_state == cdt_pkg::S_BWD_WR);

    always_comb begin
        if (w_bwd) begin
            w_center  = r_rdb_q;
            w_en.prev = !w_x_last;
            w_en.near = !w_y_last;
            w_en.diag = !w_x_last && !w_y_last;
            w_en.far  = !w_x_first && !w_y_last;
        end else begin
            w_center  = r_set ? '0 : cdt_pkg::DIST_INF;
            w_en.prev = !w_x_first;
            w_en.near = !w_y_first;
            w_en.diag = !w_x_first && !w_y_first;
            w_en.far  = !w_x_last && !w_y_first;
        end
    end

    cdt_relax u_relax (
        .i_center (w_center),
        .i_prev   (r_prev),
        .i_near   (r_near),
        .i_diag   (r_diag),
        .i_far    (r_rda_q),
        .i_en     (w_en),
        .o_dist   (w_new)
    );

    // ---------------------------------------------------------------
    // FSM: next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            cdt_pkg::S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = (i_op == cdt_pkg::OP_READ) ? cdt_pkg::S_READ : cdt_pkg::S_LOAD;
                end
            end
            cdt_pkg::S_LOAD: begin
                n_state = w_last_px ? cdt_pkg::S_BWD_RD : cdt_pkg::S_IDLE;
            end
            cdt_pkg::S_BWD_RD: begin
                n_state = cdt_pkg::S_BWD_WR;
            end
            cdt_pkg::S_BWD_WR: begin
                n_state = (r_cnt == '0) ? cdt_pkg::S_IDLE : cdt_pkg::S_BWD_RD;
            end
            cdt_pkg::S_READ: begin
                if (w_out_free) begin
                    n_state = cdt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cdt_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // FSM: outputs (handshake and memory ports)
    // ---------------------------------------------------------------
    always_comb begin
        o_in_ready = 1'b0;
        w_rda_en   = 1'b0;
        w_rda_addr = w_fwd_addr[AW-1:0];
        w_rdb_en   = 1'b0;
        w_rdb_addr = r_cnt[AW-1:0];
        w_wr_en    = 1'b0;
        w_wr_addr  = r_cnt[AW-1:0];
        case (r_state)
            cdt_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    w_rda_en   = 1'b1;
                    w_rda_addr = (i_op == cdt_pkg::OP_READ) ? w_idx_ext[AW-1:0]
                                                             : w_fwd_addr[AW-1:0];
                end
            end
            cdt_pkg::S_LOAD: begin
                w_wr_en = 1'b1;
            end
            cdt_pkg::S_BWD_RD: begin
                w_rda_en   = 1'b1;
                w_rda_addr = w_bwd_addr[AW-1:0];
                w_rdb_en   = 1'b1;
            end
            cdt_pkg::S_BWD_WR: begin
                w_wr_en = 1'b1;
            end
            cdt_pkg::S_READ: begin
                o_in_ready = 1'b0;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Memory
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_new;
        end
        if (w_rda_en) begin
            r_rda_q <= r_mem[w_rda_addr];
        end
        if (w_rdb_en) begin
            r_rdb_q <= r_mem[w_rdb_addr];
        end
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= cdt_pkg::S_IDLE;
            r_w          <= WW'(W_RST);
            r_h          <= HW'(H_RST);
            r_cnt        <= '0;
            r_x          <= '0;
            r_y          <= '0;
            r_frame_done <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            // a load after a finished frame starts a new one at index 0
            if (r_state == cdt_pkg::S_IDLE && w_in_xfer && i_op == cdt_pkg::OP_LOAD
                && w_restart) begin
                r_cnt        <= '0;
                r_x          <= '0;
                r_y          <= '0;
                r_frame_done <= 1'b0;
            end

            // forward step; on the last pixel the position is kept for backward
            if (r_state == cdt_pkg::S_LOAD && !w_last_px) begin
                r_cnt <= r_cnt + CW'(1);
                if (w_x_last) begin
                    r_x <= '0;
                    r_y <= r_y + HW'(1);
                end else begin
                    r_x <= r_x + WW'(1);
                end
            end

            if (r_state == cdt_pkg::S_BWD_WR) begin
                if (r_cnt == '0) begin
                    r_frame_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CW'(1);
                    if (w_x_first) begin
                        r_x <= r_w - WW'(1);
                        r_y <= r_y - HW'(1);
                    end else begin
                        r_x <= r_x - WW'(1);
                    end
                end
            end

            if (r_state == cdt_pkg::S_READ && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            // geometry write restarts the frame
            if (i_cfg_we && i_cfg_index == cdt_pkg::CFG_WIDTH) begin
                r_w          <= w_cfg_w;
                r_cnt        <= '0;
                r_x          <= '0;
                r_y          <= '0;
                r_frame_done <= 1'b0;
            end else if (i_cfg_we && i_cfg_index == cdt_pkg::CFG_HEIGHT) begin
                r_h          <= w_cfg_h;
                r_cnt        <= '0;
                r_x          <= '0;
                r_y          <= '0;
                r_frame_done <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Payload registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (r_state == cdt_pkg::S_IDLE && w_in_xfer) begin
            r_set   <= i_pixel_set;
            r_rd_ok <= r_frame_done && w_idx_in;
        end

        // slide the window; with one-pixel rows the next neighbor is this pixel
        if (r_state == cdt_pkg::S_LOAD || r_state == cdt_pkg::S_BWD_WR) begin
            r_prev <= w_new;
            r_diag <= r_near;
            r_near <= w_w_one ? w_new : r_rda_q;
        end

        if (r_state == cdt_pkg::S_READ && w_out_free) begin
            r_distance  <= r_rd_ok ? r_rda_q : '0;
            r_ready_res <= r_rd_ok;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_distance  = r_distance;
    assign o_ready_res = r_ready_res;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_done_from_bwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_frame_done) |-> $past(r_state) == cdt_pkg::S_BWD_WR)
        else $error("frame_done set outside backward pass");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= w_n)
        else $error("pixel index beyond frame size");

    a_last_to_bwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cdt_pkg::S_LOAD && w_last_px) |=> r_state == cdt_pkg::S_BWD_RD)
        else $error("last pixel did not start backward pass");

    a_bwd_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cdt_pkg::S_BWD_WR) |-> (r_cnt < w_n))
        else $error("backward write outside frame");

endmodule
